// ----- rtl/core/rvc_pkg.sv -----
// ----------------------------------------------------------------------------
// rvc_pkg
// Shared widths, fixed-point constants and register indexes for the radial
// vignetting correction datapath.
// ----------------------------------------------------------------------------
package rvc_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_COEF0  = 3'd2,
    REG_COEF1  = 3'd3,
    REG_COEF2  = 3'd4,
    REG_COEF3  = 3'd5
  } cfg_reg_e;

  // parameter defaults
  localparam int unsigned TERMS_DEF      = 4;
  localparam int unsigned MAX_DIM_DEF    = 4096;
  localparam int unsigned PIXEL_BITS_DEF = 16;

  // field widths
  localparam int unsigned DIM_W  = 13;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned COEF_W = 16;
  localparam int unsigned NCOEF  = 4;

  // reset values
  localparam logic [DIM_W-1:0]         DIM_RST   = 13'd4096;
  localparam logic signed [COEF_W-1:0] COEF0_RST = 16'sd4096;

  // fixed point
  localparam int unsigned FRAC      = 16;            // Q.16 radius terms
  localparam int unsigned ROUND_Q16 = 32768;
  localparam int unsigned MAG_W     = 14;            // |2*pos-(s-1)|
  localparam int unsigned NX_W      = 18;            // saturated |nx|
  localparam int unsigned R2_W      = 20;
  localparam int unsigned R2_CAP    = 524288;        // 8.0 in Q.16
  localparam int unsigned P2_W      = 23;
  localparam int unsigned P3_W      = 26;
  localparam int unsigned A_W       = 44;            // signed Q.28 sum
  localparam int unsigned ATT_FRAC  = 28;
  localparam int unsigned ATT_FLOOR = 26843546;      // 0.1 in Q.28

endpackage

// ----- rtl/core/rvc_div_cell.sv -----
// ----------------------------------------------------------------------------
// rvc_div_cell
// One restoring-division step: resolves one quotient bit per lane and hands
// remainder, divisor and sideband to the next cell.
// ----------------------------------------------------------------------------
module rvc_div_cell #(
  parameter int unsigned LANES  = 1,
  parameter int unsigned DV_W   = 8,
  parameter int unsigned Q_W    = 8,
  parameter int unsigned BIT    = 0,
  parameter int unsigned SIDE_W = 1,
  localparam int unsigned RW    = DV_W + Q_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [LANES-1:0][RW-1:0]    rem_i,
  input  logic [LANES-1:0][DV_W-1:0]  dvs_i,
  input  logic [LANES-1:0][Q_W-1:0]   quo_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        vld_o,
  output logic [LANES-1:0][RW-1:0]    rem_o,
  output logic [LANES-1:0][DV_W-1:0]  dvs_o,
  output logic [LANES-1:0][Q_W-1:0]   quo_o,
  output logic [SIDE_W-1:0]           side_o
);

  logic [LANES-1:0][RW-1:0]  shf;
  logic [LANES-1:0][RW-1:0]  rem_d;
  logic [LANES-1:0][Q_W-1:0] quo_d;
  logic                      vld_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      shf[l] = RW'(dvs_i[l]) << BIT;
      if (rem_i[l] >= shf[l]) begin
        rem_d[l] = rem_i[l] - shf[l];
        quo_d[l] = quo_i[l] | (Q_W'(1) << BIT);
      end else begin
        rem_d[l] = rem_i[l];
        quo_d[l] = quo_i[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      dvs_o  <= dvs_i;
      quo_o  <= quo_d;
      side_o <= side_i;
    end
  end

  assign vld_o = vld_q;

endmodule

// ----- rtl/core/rvc_div.sv -----
// ----------------------------------------------------------------------------
// rvc_div
// Pipelined divider: a row of Q_W division cells, one quotient bit per cell,
// most significant bit first. Dividend must be below divisor * 2^Q_W.
// ----------------------------------------------------------------------------
module rvc_div #(
  parameter int unsigned LANES  = 1,
  parameter int unsigned DV_W   = 8,
  parameter int unsigned Q_W    = 8,
  parameter int unsigned SIDE_W = 1,
  localparam int unsigned RW    = DV_W + Q_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [LANES-1:0][RW-1:0]    dvd_i,
  input  logic [LANES-1:0][DV_W-1:0]  dvs_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        vld_o,
  output logic [LANES-1:0][Q_W-1:0]   quo_o,
  output logic [SIDE_W-1:0]           side_o
);

  logic                       vld_c  [Q_W+1];
  logic [LANES-1:0][RW-1:0]   rem_c  [Q_W];
  logic [LANES-1:0][DV_W-1:0] dvs_c  [Q_W];
  logic [LANES-1:0][Q_W-1:0]  quo_c  [Q_W+1];
  logic [SIDE_W-1:0]          side_c [Q_W+1];

  assign vld_c[0]  = vld_i;
  assign rem_c[0]  = dvd_i;
  assign dvs_c[0]  = dvs_i;
  assign quo_c[0]  = '0;
  assign side_c[0] = side_i;

  for (genvar k = 0; k < Q_W; k++) begin : g_cell
    if (k < Q_W - 1) begin : g_mid
      rvc_div_cell #(
        .LANES(LANES), .DV_W(DV_W), .Q_W(Q_W), .BIT(Q_W - 1 - k), .SIDE_W(SIDE_W)
      ) u_cell (
        .clk_i, .rst_ni, .en_i,
        .vld_i (vld_c[k]),   .rem_i (rem_c[k]),   .dvs_i (dvs_c[k]),
        .quo_i (quo_c[k]),   .side_i(side_c[k]),
        .vld_o (vld_c[k+1]), .rem_o (rem_c[k+1]), .dvs_o (dvs_c[k+1]),
        .quo_o (quo_c[k+1]), .side_o(side_c[k+1])
      );
    end else begin : g_last
      rvc_div_cell #(
        .LANES(LANES), .DV_W(DV_W), .Q_W(Q_W), .BIT(Q_W - 1 - k), .SIDE_W(SIDE_W)
      ) u_cell (
        .clk_i, .rst_ni, .en_i,
        .vld_i (vld_c[k]),   .rem_i (rem_c[k]),   .dvs_i (dvs_c[k]),
        .quo_i (quo_c[k]),   .side_i(side_c[k]),
        .vld_o (vld_c[k+1]), .rem_o (),           .dvs_o (),
        .quo_o (quo_c[k+1]), .side_o(side_c[k+1])
      );
    end
  end

  assign vld_o  = vld_c[Q_W];
  assign quo_o  = quo_c[Q_W];
  assign side_o = side_c[Q_W];

endmodule

// ----- rtl/core/radial_vignetting_correction.sv -----
// ----------------------------------------------------------------------------
// radial_vignetting_correction
// Throughput: one pixel beat per cycle while the output beat is not stuck; the
// two rows of divide cells (18 for the offsets, PIXEL_BITS for the channels)
// resolve one bit per stage.
// Reset: valid bits clear; registers return to 4096 x 4096, unity gain.
// ----------------------------------------------------------------------------
module radial_vignetting_correction #(
  parameter int unsigned TERMS      = rvc_pkg::TERMS_DEF,
  parameter int unsigned MAX_DIM    = rvc_pkg::MAX_DIM_DEF,
  parameter int unsigned PIXEL_BITS = rvc_pkg::PIXEL_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [rvc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rvc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // pixel input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [PIXEL_BITS-1:0]           red_in_i,
  input  logic [PIXEL_BITS-1:0]           green_in_i,
  input  logic [PIXEL_BITS-1:0]           blue_in_i,
  input  logic [rvc_pkg::POS_W-1:0]       column_i,
  input  logic [rvc_pkg::POS_W-1:0]       row_i,
  // corrected pixel output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [PIXEL_BITS-1:0]           red_out_o,
  output logic [PIXEL_BITS-1:0]           green_out_o,
  output logic [PIXEL_BITS-1:0]           blue_out_o
);

  import rvc_pkg::*;

  localparam int unsigned PW   = PIXEL_BITS;
  localparam int unsigned RW_X = DIM_W + NX_W;     // offset divider width
  localparam int unsigned DV_C = A_W - 1;          // attenuation, unsigned
  localparam int unsigned RW_C = DV_C + PW;        // channel divider width
  localparam logic signed [A_W-1:0] FLOOR_S = A_W'(ATT_FLOOR);

  typedef logic [2:0][PW-1:0] pix_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0]         width_q, height_q;
  logic signed [COEF_W-1:0] coef_q [NCOEF];
  logic signed [COEF_W-1:0] coef_use [NCOEF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= DIM_RST;
      height_q  <= DIM_RST;
      coef_q[0] <= COEF0_RST;
      coef_q[1] <= '0;
      coef_q[2] <= '0;
      coef_q[3] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH:  width_q   <= cfg_data_i[DIM_W-1:0];
        REG_HEIGHT: height_q  <= cfg_data_i[DIM_W-1:0];
        REG_COEF0:  coef_q[0] <= cfg_data_i;
        REG_COEF1:  coef_q[1] <= cfg_data_i;
        REG_COEF2:  coef_q[2] <= cfg_data_i;
        REG_COEF3:  coef_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Drop coefficients beyond the configured polynomial length.
  always_comb begin
    for (int k = 0; k < NCOEF; k++) begin
      coef_use[k] = (k < TERMS) ? coef_q[k] : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: every stage advances together unless the output beat is
  // stuck. Bubbles still travel, so the block keeps taking beats while the
  // output register is empty or being drained.
  // --------------------------------------------------------------------------
  logic adv;
  logic out_vld_q;

  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // --------------------------------------------------------------------------
  // Stage A: offset magnitude, rounded dividend for the normalization divide
  // --------------------------------------------------------------------------
  function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] s);
    logic [DIM_W-1:0] r;
    r = s;
    if (s == '0) r = DIM_W'(1);
    else if (32'(s) > MAX_DIM) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] den_of(input logic [DIM_W-1:0] s);
    logic [DIM_W-1:0] m;
    m = s - DIM_W'(1);
    return (m < DIM_W'(2)) ? DIM_W'(2) : m;
  endfunction

  function automatic logic [MAG_W-1:0] mag_of(input logic [POS_W-1:0] pos,
                                               input logic [DIM_W-1:0] s);
    logic signed [MAG_W:0] d;
    d = $signed({2'b00, pos, 1'b0}) - $signed({2'b00, s - DIM_W'(1)});
    if (d < 0) d = -d;
    return d[MAG_W-1:0];
  endfunction

  logic [DIM_W-1:0] sx, sy, denx, deny;
  logic [RW_X-1:0]  dvdx, dvdy;
  logic             ovfx, ovfy;

  always_comb begin
    sx   = eff_size(width_q);
    sy   = eff_size(height_q);
    denx = den_of(sx);
    deny = den_of(sy);
    dvdx = RW_X'({mag_of(column_i, sx), FRAC'(0)}) + RW_X'(denx >> 1);
    dvdy = RW_X'({mag_of(row_i, sy), FRAC'(0)}) + RW_X'(deny >> 1);
    // quotient at or above 2^NX_W: r squared caps anyway
    ovfx = dvdx >= {denx, NX_W'(0)};
    ovfy = dvdy >= {deny, NX_W'(0)};
  end

  logic                         a_vld_q;
  logic [1:0][RW_X-1:0]         a_dvd_q;
  logic [1:0][DIM_W-1:0]        a_den_q;
  logic [3*PW+1:0]              a_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_dvd_q  <= {dvdy, dvdx};
      a_den_q  <= {deny, denx};
      a_side_q <= {ovfy, ovfx, blue_in_i, green_in_i, red_in_i};
    end
  end

  // --------------------------------------------------------------------------
  // Normalization divide, x and y lanes side by side
  // --------------------------------------------------------------------------
  logic                  xy_vld;
  logic [1:0][NX_W-1:0]  xy_quo;
  logic [3*PW+1:0]       xy_side;

  rvc_div #(
    .LANES (2),
    .DV_W  (DIM_W),
    .Q_W   (NX_W),
    .SIDE_W(3*PW+2)
  ) u_div_xy (
    .clk_i,
    .rst_ni,
    .en_i  (adv),
    .vld_i (a_vld_q),
    .dvd_i (a_dvd_q),
    .dvs_i (a_den_q),
    .side_i(a_side_q),
    .vld_o (xy_vld),
    .quo_o (xy_quo),
    .side_o(xy_side)
  );

  // --------------------------------------------------------------------------
  // Stages B..J: radius and attenuation polynomial
  // --------------------------------------------------------------------------
  logic [NX_W-1:0]       nxs [2];
  logic [2*NX_W-1:0]     sq_d [2];
  logic [2*NX_W:0]       r2_sum;
  logic [2*NX_W-FRAC:0]  r2_raw;
  logic [R2_W-1:0]       r2_d;
  logic [2*R2_W:0]       p2_rnd;
  logic [P2_W+R2_W:0]    p3_rnd;

  logic signed [COEF_W+FRAC-1:0] t0_d;
  logic signed [COEF_W+R2_W:0]   t1_d;
  logic signed [COEF_W+P2_W:0]   t2_d;
  logic signed [COEF_W+P3_W:0]   t3_d;
  logic signed [A_W-1:0]         s01_d, s23_d, att_sum;
  logic [DV_C-1:0]               att_d;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      nxs[l]  = xy_side[3*PW+l] ? '1 : xy_quo[l];
      sq_d[l] = nxs[l] * nxs[l];
    end
  end

  logic              b_vld_q, c_vld_q, d_vld_q, e_vld_q, f_vld_q;
  logic              g_vld_q, h_vld_q, i_vld_q, j_vld_q;
  pix_t              b_pix_q, c_pix_q, d_pix_q, e_pix_q, f_pix_q;
  pix_t              g_pix_q, h_pix_q, i_pix_q, j_pix_q;
  logic [2*NX_W-1:0] b_sq_q [2];
  logic [R2_W-1:0]   c_r2_q, d_r2_q, e_r2_q, f_r2_q, g_r2_q;
  logic [2*R2_W-1:0] d_p2_q;
  logic [P2_W-1:0]   e_pw2_q, f_pw2_q, g_pw2_q;
  logic [P2_W+R2_W-1:0] f_p3_q;
  logic [P3_W-1:0]   g_pw3_q;
  logic signed [COEF_W+FRAC-1:0] h_t0_q;
  logic signed [COEF_W+R2_W:0]   h_t1_q;
  logic signed [COEF_W+P2_W:0]   h_t2_q;
  logic signed [COEF_W+P3_W:0]   h_t3_q;
  logic signed [A_W-1:0]         i_s01_q, i_s23_q;
  logic [DV_C-1:0]               j_att_q;

  always_comb begin
    // Stage C: r squared, rounded and capped at 8.0
    r2_sum = {1'b0, b_sq_q[0]} + {1'b0, b_sq_q[1]} + (2*NX_W+1)'(ROUND_Q16);
    r2_raw = r2_sum[2*NX_W:FRAC];
    r2_d   = (r2_raw > (2*NX_W-FRAC+1)'(R2_CAP)) ? R2_W'(R2_CAP) : r2_raw[R2_W-1:0];
    // Stages E and G: round the power products back to Q.16
    p2_rnd = {1'b0, d_p2_q} + (2*R2_W+1)'(ROUND_Q16);
    p3_rnd = {1'b0, f_p3_q} + (P2_W+R2_W+1)'(ROUND_Q16);
    // Stage H: coefficient products
    t0_d = $signed({coef_use[0], FRAC'(0)});
    t1_d = coef_use[1] * $signed({1'b0, g_r2_q});
    t2_d = coef_use[2] * $signed({1'b0, g_pw2_q});
    t3_d = coef_use[3] * $signed({1'b0, g_pw3_q});
    // Stage I: pairwise sums
    s01_d = A_W'(h_t0_q) + A_W'(h_t1_q);
    s23_d = A_W'(h_t2_q) + A_W'(h_t3_q);
    // Stage J: total, floored at 0.1
    att_sum = i_s01_q + i_s23_q;
    att_d   = (att_sum < FLOOR_S) ? FLOOR_S[DV_C-1:0] : att_sum[DV_C-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
      h_vld_q <= 1'b0;
      i_vld_q <= 1'b0;
      j_vld_q <= 1'b0;
    end else if (adv) begin
      b_vld_q <= xy_vld;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
      f_vld_q <= e_vld_q;
      g_vld_q <= f_vld_q;
      h_vld_q <= g_vld_q;
      i_vld_q <= h_vld_q;
      j_vld_q <= i_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_pix_q <= xy_side[3*PW-1:0];
      b_sq_q  <= sq_d;
      c_pix_q <= b_pix_q;
      c_r2_q  <= r2_d;
      d_pix_q <= c_pix_q;
      d_r2_q  <= c_r2_q;
      d_p2_q  <= c_r2_q * c_r2_q;
      e_pix_q <= d_pix_q;
      e_r2_q  <= d_r2_q;
      e_pw2_q <= p2_rnd[P2_W+FRAC-1:FRAC];
      f_pix_q <= e_pix_q;
      f_r2_q  <= e_r2_q;
      f_pw2_q <= e_pw2_q;
      f_p3_q  <= e_pw2_q * e_r2_q;
      g_pix_q <= f_pix_q;
      g_r2_q  <= f_r2_q;
      g_pw2_q <= f_pw2_q;
      g_pw3_q <= p3_rnd[P3_W+FRAC-1:FRAC];
      h_pix_q <= g_pix_q;
      h_t0_q  <= t0_d;
      h_t1_q  <= t1_d;
      h_t2_q  <= t2_d;
      h_t3_q  <= t3_d;
      i_pix_q <= h_pix_q;
      i_s01_q <= s01_d;
      i_s23_q <= s23_d;
      j_pix_q <= i_pix_q;
      j_att_q <= att_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage K: channel dividends (pixel scaled to Q.28 plus half the divisor)
  // and saturation flags; a quotient of 2^PW or more clips to full code.
  // --------------------------------------------------------------------------
  logic [2:0][RW_C-1:0] dvdc;
  logic [2:0]           satc;
  logic [2:0][DV_C-1:0] attc;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dvdc[c] = (RW_C'(j_pix_q[c]) << ATT_FRAC) + RW_C'(j_att_q >> 1);
      satc[c] = dvdc[c] >= (RW_C'(j_att_q) << PW);
      attc[c] = j_att_q;
    end
  end

  logic                 k_vld_q;
  logic [2:0][RW_C-1:0] k_dvd_q;
  logic [2:0][DV_C-1:0] k_att_q;
  logic [2:0]           k_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_vld_q <= 1'b0;
    end else if (adv) begin
      k_vld_q <= j_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      k_dvd_q <= dvdc;
      k_att_q <= attc;
      k_sat_q <= satc;
    end
  end

  // --------------------------------------------------------------------------
  // Channel divide, red/green/blue lanes
  // --------------------------------------------------------------------------
  logic               ch_vld;
  logic [2:0][PW-1:0] ch_quo;
  logic [2:0]         ch_sat;

  rvc_div #(
    .LANES (3),
    .DV_W  (DV_C),
    .Q_W   (PW),
    .SIDE_W(3)
  ) u_div_ch (
    .clk_i,
    .rst_ni,
    .en_i  (adv),
    .vld_i (k_vld_q),
    .dvd_i (k_dvd_q),
    .dvs_i (k_att_q),
    .side_i(k_sat_q),
    .vld_o (ch_vld),
    .quo_o (ch_quo),
    .side_o(ch_sat)
  );

  // --------------------------------------------------------------------------
  // Output register: clip and hold the beat until taken
  // --------------------------------------------------------------------------
  pix_t out_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= ch_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        out_pix_q[c] <= ch_sat[c] ? '1 : ch_quo[c];
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign red_out_o   = out_pix_q[0];
  assign green_out_o = out_pix_q[1];
  assign blue_out_o  = out_pix_q[2];

endmodule
